// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked on the rising clock edge, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/sme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine package
// Shared widths, opcodes, status codes and the shared-unit request and response types.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned SpWidth    = $clog2(StackDepth + 1);
  localparam int unsigned SaWidth    = $clog2(StackDepth);
  localparam int unsigned ImmBytes   = DataWidth / 8;
  localparam int unsigned TgtBytes   = 4;
  localparam int unsigned CntWidth   = $clog2(DataWidth + 1);

  localparam logic [4:0] OpPush  = 5'd0;
  localparam logic [4:0] OpRpush = 5'd1;
  localparam logic [4:0] OpPop   = 5'd2;
  localparam logic [4:0] OpAdd   = 5'd3;
  localparam logic [4:0] OpSub   = 5'd4;
  localparam logic [4:0] OpMul   = 5'd5;
  localparam logic [4:0] OpDiv   = 5'd6;
  localparam logic [4:0] OpSqrt  = 5'd7;
  localparam logic [4:0] OpIn    = 5'd8;
  localparam logic [4:0] OpOut   = 5'd9;
  localparam logic [4:0] OpJmp   = 5'd10;
  localparam logic [4:0] OpJa    = 5'd11;
  localparam logic [4:0] OpJae   = 5'd12;
  localparam logic [4:0] OpJb    = 5'd13;
  localparam logic [4:0] OpJbe   = 5'd14;
  localparam logic [4:0] OpJe    = 5'd15;
  localparam logic [4:0] OpJne   = 5'd16;
  localparam logic [4:0] OpCall  = 5'd17;
  localparam logic [4:0] OpRet   = 5'd18;
  localparam logic [4:0] OpHlt   = 5'd19;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnder   = 3'd1;
  localparam logic [2:0] StOver    = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StBadReg  = 3'd4;
  localparam logic [2:0] StBadOp   = 3'd5;
  localparam logic [2:0] StNegSqrt = 3'd6;

  typedef enum logic [1:0] {
    AluMul,
    AluDiv,
    AluSqrt
  } alu_op_e;

  typedef struct packed {
    logic                 start;
    alu_op_e              op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] result;
  } alu_rsp_t;

endpackage

// ----- rtl/core/stack_machine_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute core
// Executes one decoded instruction per input transaction.
// ----------------------------------------------------------------------------
// One instruction is taken at a time and s_axis_tready stays low until its
// result has been handed over. Simple instructions pass from acceptance
// through the two read states, the execute state and the output state,
// reading the top two stack words from the stack memory one per cycle.
// Multiply, divide and square root also wait in the unit state for the shared
// iterative unit that produces one result bit (two radicand bits for square
// root) per cycle. The result register frees the input side as soon as the result is taken.
module stack_machine_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[4:0], push_value[36:5], reg_sel[44:37], jump_target[60:45],
  // in_value[92:61], zero fill[95:93]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[15:0], out_valid[16], out_value[48:17], halted[49], status[52:50],
  // zero fill[55:53]
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned W  = sme_pkg::DataWidth;
  localparam int unsigned AW = sme_pkg::AddrWidth;
  localparam int unsigned SW = sme_pkg::SpWidth;
  localparam int unsigned SA = sme_pkg::SaWidth;

  typedef enum logic [2:0] {
    StIdle,
    StRd1,
    StRd2,
    StExec,
    StAlu,
    StOut
  } state_e;

  state_e           state_q;
  logic [4:0]       cmd_q;
  logic [W-1:0]     imm_q;
  logic [7:0]       rsel_q;
  logic [AW-1:0]    tgt_q;
  logic [W-1:0]     inv_q;
  logic [AW-1:0]    pc_q;
  logic [W-1:0]     regs_q [4];
  logic [SW-1:0]    sp_q;
  logic             halt_q;
  logic [W-1:0]     top_q;
  logic [W-1:0]     stack_mem [sme_pkg::StackDepth];
  logic [W-1:0]     rd_q;
  logic [SA-1:0]    rd_addr;
  logic             rd_en;
  logic [55:0]      res_q;
  logic             mv_q;

  sme_pkg::alu_req_t alu_req;
  sme_pkg::alu_rsp_t alu_rsp;

  sme_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  logic [4:0]  in_cmd;
  assign in_cmd = s_axis_tdata[4:0];

  assign s_axis_tready = (state_q == StIdle) && !mv_q;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = res_q;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  assign rd_en   = (state_q == StRd1) || (state_q == StRd2);
  assign rd_addr = (state_q == StRd1) ? SA'(sp_q - SW'(1)) : SA'(sp_q - SW'(2));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  // Execution decode. From the execute state on, rd_q holds the next word.
  logic          take, fault;
  logic [2:0]    st;
  logic [AW-1:0] seq_pc, nx_pc, ret_pc;
  logic          w_en;
  logic [SA-1:0] w_addr;
  logic [W-1:0]  w_data;
  logic [SW-1:0] sp_n;
  logic          go_alu;
  sme_pkg::alu_op_e aop;
  logic          lt_vd, lt_dv;

  assign lt_vd    = $signed(top_q) < $signed(regs_q[3]);
  assign lt_dv    = $signed(regs_q[3]) < $signed(top_q);
  assign ret_pc   = pc_q + AW'(1 + sme_pkg::TgtBytes);

  always_comb begin
    st     = sme_pkg::StOk;
    seq_pc = pc_q + AW'(1);
    take   = 1'b0;
    w_en   = 1'b0;
    w_addr = SA'(sp_q);
    w_data = top_q;
    sp_n   = sp_q;
    go_alu = 1'b0;
    aop    = sme_pkg::AluMul;
    case (cmd_q)
      sme_pkg::OpPush, sme_pkg::OpIn: begin
        if (cmd_q == sme_pkg::OpPush) seq_pc = pc_q + AW'(1 + sme_pkg::ImmBytes);
        if (sp_q >= SW'(sme_pkg::StackDepth)) begin
          st = sme_pkg::StOver;
        end else begin
          w_en   = 1'b1;
          w_data = (cmd_q == sme_pkg::OpPush) ? imm_q : inv_q;
          sp_n   = sp_q + SW'(1);
        end
      end
      sme_pkg::OpRpush: begin
        seq_pc = pc_q + AW'(2);
        if (rsel_q > 8'd3) st = sme_pkg::StBadReg;
        else if (sp_q >= SW'(sme_pkg::StackDepth)) st = sme_pkg::StOver;
        else begin
          w_en   = 1'b1;
          w_data = regs_q[rsel_q[1:0]];
          sp_n   = sp_q + SW'(1);
        end
      end
      sme_pkg::OpPop: begin
        seq_pc = pc_q + AW'(2);
        if (rsel_q > 8'd3) st = sme_pkg::StBadReg;
        else if (sp_q == '0) st = sme_pkg::StUnder;
        else sp_n = sp_q - SW'(1);
      end
      sme_pkg::OpAdd, sme_pkg::OpSub, sme_pkg::OpMul, sme_pkg::OpDiv: begin
        if (sp_q < SW'(2)) st = sme_pkg::StUnder;
        else if (cmd_q == sme_pkg::OpDiv && top_q == '0) st = sme_pkg::StDivZero;
        else begin
          w_en   = 1'b1;
          w_addr = SA'(sp_q - SW'(2));
          sp_n   = sp_q - SW'(1);
          w_data = (cmd_q == sme_pkg::OpAdd) ? top_q + rd_q : top_q - rd_q;
          if (cmd_q == sme_pkg::OpMul) begin
            go_alu = 1'b1;
            aop    = sme_pkg::AluMul;
          end else if (cmd_q == sme_pkg::OpDiv) begin
            go_alu = 1'b1;
            aop    = sme_pkg::AluDiv;
          end
        end
      end
      sme_pkg::OpSqrt: begin
        if (sp_q == '0) st = sme_pkg::StUnder;
        else if (top_q[W-1]) st = sme_pkg::StNegSqrt;
        else begin
          w_en   = 1'b1;
          w_addr = SA'(sp_q - SW'(1));
          go_alu = 1'b1;
          aop    = sme_pkg::AluSqrt;
        end
      end
      sme_pkg::OpOut: begin
        if (sp_q == '0) st = sme_pkg::StUnder;
        else sp_n = sp_q - SW'(1);
      end
      sme_pkg::OpJmp: take = 1'b1;
      sme_pkg::OpJa, sme_pkg::OpJae, sme_pkg::OpJb, sme_pkg::OpJbe,
      sme_pkg::OpJe, sme_pkg::OpJne: begin
        seq_pc = ret_pc;
        if (sp_q == '0) st = sme_pkg::StUnder;
        else begin
          sp_n = sp_q - SW'(1);
          case (cmd_q)
            sme_pkg::OpJa:  take = lt_dv;
            sme_pkg::OpJae: take = !lt_vd;
            sme_pkg::OpJb:  take = lt_vd;
            sme_pkg::OpJbe: take = !lt_dv;
            sme_pkg::OpJe:  take = top_q == regs_q[3];
            default:        take = top_q != regs_q[3];
          endcase
        end
      end
      sme_pkg::OpCall: take = 1'b1;
      sme_pkg::OpRet, sme_pkg::OpHlt: ;
      default: st = sme_pkg::StBadOp;
    endcase
    if (cmd_q == sme_pkg::OpRet) nx_pc = regs_q[3][AW-1:0];
    else nx_pc = take ? tgt_q : seq_pc;
  end

  assign fault = (st != sme_pkg::StOk);
  assign alu_req.start = (state_q == StExec) && go_alu;
  assign alu_req.op    = aop;
  assign alu_req.a     = (cmd_q == sme_pkg::OpDiv) ? rd_q : top_q;
  assign alu_req.b     = (cmd_q == sme_pkg::OpDiv) ? top_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StExec && w_en && !go_alu) begin
      stack_mem[w_addr] <= w_data;
    end else if (state_q == StAlu && alu_rsp.done) begin
      stack_mem[w_addr] <= alu_rsp.result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mv_q    <= 1'b0;
      pc_q    <= '0;
      sp_q    <= '0;
      halt_q  <= 1'b0;
      regs_q  <= '{default: '0};
      res_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (mv_q && m_axis_tready) mv_q <= 1'b0;
          if (s_fire) begin
            if (halt_q) begin
              res_q   <= {3'b000, sme_pkg::StOk, 1'b1, 32'd0, 1'b0, pc_q};
              state_q <= StOut;
            end else begin
              state_q <= StRd1;
            end
          end
        end
        StRd1:  state_q <= StRd2;
        StRd2:  state_q <= StExec;
        StExec: begin
          state_q <= go_alu ? StAlu : StOut;
          if (!go_alu) begin
            pc_q <= nx_pc;
            if (!fault) sp_q <= sp_n;
            if (cmd_q == sme_pkg::OpPop && !fault) regs_q[rsel_q[1:0]] <= top_q;
            if (cmd_q == sme_pkg::OpCall) begin
              regs_q[3] <= W'(ret_pc);
            end
            if (cmd_q == sme_pkg::OpHlt || st == sme_pkg::StBadOp) halt_q <= 1'b1;
            res_q <= {3'b000, st,
                      (cmd_q == sme_pkg::OpHlt) || (st == sme_pkg::StBadOp),
                      (cmd_q == sme_pkg::OpOut && !fault) ? top_q : W'(0),
                      (cmd_q == sme_pkg::OpOut) && !fault, nx_pc};
          end
        end
        StAlu: begin
          if (alu_rsp.done) begin
            pc_q    <= nx_pc;
            sp_q    <= sp_n;
            res_q   <= {3'b000, sme_pkg::StOk, 1'b0, W'(0), 1'b0, nx_pc};
            state_q <= StOut;
          end
        end
        StOut: begin
          mv_q    <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Instruction capture at acceptance and top word after the first read.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q  <= in_cmd;
      imm_q  <= s_axis_tdata[36:5];
      rsel_q <= s_axis_tdata[44:37];
      tgt_q  <= s_axis_tdata[60:45];
      inv_q  <= s_axis_tdata[92:61];
    end
    if (state_q == StRd2) top_q <= rd_q;
  end

endmodule

// ----- rtl/core/sme_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine iterative unit
// Shift-add multiply, restoring divide and digit-by-digit square root, one
// result bit per cycle through one shared adder.
// ----------------------------------------------------------------------------
module sme_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sme_pkg::alu_req_t req_i,
  output sme_pkg::alu_rsp_t rsp_o
);

  localparam int unsigned W = sme_pkg::DataWidth;

  logic                          busy_q, busy_d;
  logic [sme_pkg::CntWidth-1:0]  cnt_q, cnt_d;
  sme_pkg::alu_op_e              op_q, op_d;
  logic [W-1:0]                  acc_q, acc_d;
  logic [W-1:0]                  x_q, x_d;
  logic [W-1:0]                  y_q, y_d;
  logic                          neg_q, neg_d;
  logic                          done_q, done_d;
  logic [W-1:0]                  res_q, res_d;

  logic [W:0]   sum;
  logic [W-1:0] a_abs, b_abs, rem_sh, trial;
  logic         a_neg, b_neg;

  assign a_neg = req_i.a[W-1];
  assign b_neg = req_i.b[W-1];
  assign a_abs = a_neg ? (W'(0) - req_i.a) : req_i.a;
  assign b_abs = b_neg ? (W'(0) - req_i.b) : req_i.b;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    rem_sh = '0;
    trial  = '0;
    sum    = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = '0;
      neg_d  = a_neg ^ b_neg;
      case (req_i.op)
        sme_pkg::AluMul: begin
          x_d   = req_i.a;
          y_d   = req_i.b;
          cnt_d = sme_pkg::CntWidth'(W);
        end
        sme_pkg::AluDiv: begin
          x_d   = a_abs;
          y_d   = b_abs;
          cnt_d = sme_pkg::CntWidth'(W);
        end
        default: begin
          x_d   = req_i.a;
          y_d   = '0;
          cnt_d = sme_pkg::CntWidth'(W / 2);
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        sme_pkg::AluMul: begin
          sum   = {1'b0, acc_q} + {1'b0, (y_q[0] ? x_q : W'(0))};
          acc_d = sum[W-1:0];
          x_d   = {x_q[W-2:0], 1'b0};
          y_d   = {1'b0, y_q[W-1:1]};
        end
        sme_pkg::AluDiv: begin
          rem_sh = {acc_q[W-2:0], x_q[W-1]};
          sum    = {1'b0, rem_sh} - {1'b0, y_q};
          x_d    = {x_q[W-2:0], ~sum[W] | (acc_q[W-1])};
          acc_d  = (~sum[W] | acc_q[W-1]) ? sum[W-1:0] : rem_sh;
        end
        default: begin
          rem_sh = {acc_q[W-3:0], x_q[W-1:W-2]};
          trial  = {y_q[W-3:0], 2'b01};
          sum    = {1'b0, rem_sh} - {1'b0, trial};
          x_d    = {x_q[W-3:0], 2'b00};
          acc_d  = sum[W] ? rem_sh : sum[W-1:0];
          y_d    = {y_q[W-2:0], ~sum[W]};
        end
      endcase
      cnt_d = cnt_q - sme_pkg::CntWidth'(1);
      if (cnt_q == sme_pkg::CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        case (op_q)
          sme_pkg::AluMul: res_d = sum[W-1:0];
          sme_pkg::AluDiv: res_d = neg_q ? (W'(0) - x_d) : x_d;
          default:         res_d = y_d;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= sme_pkg::AluMul;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// ----- rtl/core/sme_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Stack machine port checker
// Watches the stream ports of the execute core.
// ----------------------------------------------------------------------------
module sme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `ASSERT_CLK(a_no_ready_busy, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready, "input ready while result pending")
  `ASSERT_CLK(a_one_cycle, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second accept before result")
  `ASSERT_CLK(a_status_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[52:50] != 3'd7, "status out of range")

endmodule

bind stack_machine_execute_core sme_checker u_sme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
